>>> hw/rtl/salsa_stream_cipher_assert.svh
// assertion helpers, clocked on clk with synchronous active-low rst_n
`ifndef SALSA_STREAM_CIPHER_ASSERT_SVH
`define SALSA_STREAM_CIPHER_ASSERT_SVH

// same-cycle implication
`define SALSA_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("salsa assertion failed");

// next-cycle implication
`define SALSA_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("salsa assertion failed");

`endif

>>> hw/rtl/salsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package salsa_pkg;

  typedef logic [31:0] word_t;
  typedef logic [15:0][31:0] state_t;
  typedef logic [3:0][31:0] quad_t;

  localparam logic TAG_ZERO = 1'b0;
  localparam logic TAG_NEXT = 1'b1;

  localparam logic [1:0] KEY_64  = 2'd0;
  localparam logic [1:0] KEY_128 = 2'd1;

  localparam quad_t SIGMA32 = {32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865};
  localparam quad_t SIGMA16 = {32'h6b206574, 32'h79622d36, 32'h3120646e, 32'h61707865};
  localparam quad_t SIGMA8  = {32'h6b206574, 32'h79622d38, 32'h3020646e, 32'h61707865};

  typedef struct packed {
    logic all_k;
    logic next_k;
  } kill_t;

  function automatic word_t rotl(input word_t v, input int s);
    rotl = (v << s) | (v >> (32 - s));
  endfunction

  // returns {d, c, b, a}
  function automatic quad_t qround(input word_t a, input word_t b, input word_t c,
                                   input word_t d);
    word_t a2, b2, c2, d2;
    b2 = b ^ rotl(a + d, 7);
    c2 = c ^ rotl(b2 + a, 9);
    d2 = d ^ rotl(c2 + b2, 13);
    a2 = a ^ rotl(d2 + c2, 18);
    qround = {d2, c2, b2, a2};
  endfunction

  function automatic state_t dround(input state_t x);
    state_t w;
    quad_t q;
    w = x;
    q = qround(w[0], w[4], w[8], w[12]);
    {w[12], w[8], w[4], w[0]} = q;
    q = qround(w[5], w[9], w[13], w[1]);
    {w[1], w[13], w[9], w[5]} = q;
    q = qround(w[10], w[14], w[2], w[6]);
    {w[6], w[2], w[14], w[10]} = q;
    q = qround(w[15], w[3], w[7], w[11]);
    {w[11], w[7], w[3], w[15]} = q;
    q = qround(w[0], w[1], w[2], w[3]);
    {w[3], w[2], w[1], w[0]} = q;
    q = qround(w[5], w[6], w[7], w[4]);
    {w[4], w[7], w[6], w[5]} = q;
    q = qround(w[10], w[11], w[8], w[9]);
    {w[9], w[8], w[11], w[10]} = q;
    q = qround(w[15], w[12], w[13], w[14]);
    {w[14], w[13], w[12], w[15]} = q;
    dround = w;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/salsa_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module salsa_cell (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire salsa_pkg::kill_t  kill,
  input  wire logic              in_vld,
  input  wire logic              in_tag,
  input  wire salsa_pkg::state_t in_x,
  input  wire salsa_pkg::state_t in_s,
  output logic                   out_vld,
  output logic                   out_tag,
  output salsa_pkg::state_t      out_x,
  output salsa_pkg::state_t      out_s
);
  import salsa_pkg::*;

  logic   vld_r, vld_nxt;
  logic   tag_r;
  state_t x_r, s_r;

  assign vld_nxt = in_vld & ~kill.all_k & ~(kill.next_k & (in_tag == TAG_NEXT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_r <= in_tag;
    x_r   <= dround(in_x);
    s_r   <= in_s;
  end

  assign out_vld = vld_r;
  assign out_tag = tag_r;
  assign out_x   = x_r;
  assign out_s   = s_r;
endmodule
`default_nettype wire

>>> hw/rtl/salsa_core.sv
`timescale 1ns / 1ps
`default_nettype none
module salsa_core #(
  parameter int DOUBLE_ROUNDS = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire salsa_pkg::kill_t  kill,
  input  wire logic              req_vld,
  input  wire logic              req_tag,
  input  wire salsa_pkg::state_t req_state,
  output logic                   blk_vld,
  output logic                   blk_tag,
  output salsa_pkg::state_t      blk_data
);
  import salsa_pkg::*;

  logic   vld [DOUBLE_ROUNDS+1];
  logic   tag [DOUBLE_ROUNDS+1];
  state_t xs  [DOUBLE_ROUNDS+1];
  state_t ss  [DOUBLE_ROUNDS+1];

  assign vld[0] = req_vld;
  assign tag[0] = req_tag;
  assign xs[0]  = req_state;
  assign ss[0]  = req_state;

  for (genvar i = 0; i < DOUBLE_ROUNDS; i++) begin : g_cell
    salsa_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .kill    (kill),
      .in_vld  (vld[i]),
      .in_tag  (tag[i]),
      .in_x    (xs[i]),
      .in_s    (ss[i]),
      .out_vld (vld[i+1]),
      .out_tag (tag[i+1]),
      .out_x   (xs[i+1]),
      .out_s   (ss[i+1])
    );
  end

  // feedforward add
  logic   vld_r, vld_nxt;
  logic   tag_r;
  state_t blk_r, blk_nxt;

  assign vld_nxt = vld[DOUBLE_ROUNDS] & ~kill.all_k
                 & ~(kill.next_k & (tag[DOUBLE_ROUNDS] == TAG_NEXT));

  always_comb begin
    for (int j = 0; j < 16; j++) begin
      blk_nxt[j] = xs[DOUBLE_ROUNDS][j] + ss[DOUBLE_ROUNDS][j];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_r <= tag[DOUBLE_ROUNDS];
    blk_r <= blk_nxt;
  end

  assign blk_vld  = vld_r;
  assign blk_tag  = tag_r;
  assign blk_data = blk_r;
endmodule
`default_nettype wire

>>> hw/rtl/salsa_stream_cipher.sv
// one word per cycle unless stalled; each word's result is registered, valid the next cycle
// keystream blocks come from DOUBLE_ROUNDS double-round cells plus an add stage; the next
// block is requested the cycle after one is taken and lands once through the cells and add
// stage; words wait if it is not in when 8 words of a block are used, or after a key write
// reset clears control state and key registers, key_size to 256-bit; blocks are
// regenerated after reset or any register write before the next word is taken
`timescale 1ns / 1ps
`default_nettype none
module salsa_stream_cipher #(
  parameter int DOUBLE_ROUNDS = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [63:0] in_data_in,
  input  wire logic [3:0]  in_byte_count,
  input  wire logic        in_restart,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_data_out,
  output logic [3:0]       out_count,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);
  import salsa_pkg::*;

  localparam logic [2:0] REG_KEY0  = 3'd0;
  localparam logic [2:0] REG_KEY1  = 3'd1;
  localparam logic [2:0] REG_KEY2  = 3'd2;
  localparam logic [2:0] REG_KEY3  = 3'd3;
  localparam logic [2:0] REG_NONCE = 3'd4;
  localparam logic [2:0] REG_KSIZE = 3'd5;

  logic [63:0] key0_r, key1_r, key2_r, key3_r, nonce_r;
  logic [1:0]  ksize_r;

  state_t      cur_r, zero_buf_r, next_buf_r;
  logic [2:0]  wp_r;
  logic [63:0] ctr_r;
  logic        zero_vld_r, next_vld_r, zero_have_r, next_have_r;
  logic        out_vld_r;
  logic [63:0] out_data_r;
  logic [3:0]  out_cnt_r;

  logic        cfg_wr, need_new, avail, acc, consume_new;
  logic [2:0]  p;
  state_t      new_blk, blk;
  logic [63:0] ks, mask;
  logic [3:0]  cnt;
  kill_t       kill;
  logic        req_vld, req_tag;
  logic [63:0] req_ctr;
  state_t      req_state;
  logic        blk_vld, blk_tag;
  state_t      blk_data;
  logic        land_zero, land_next;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key0_r  <= '0;
      key1_r  <= '0;
      key2_r  <= '0;
      key3_r  <= '0;
      nonce_r <= '0;
      ksize_r <= 2'd2;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_KEY0:  key0_r  <= cfg_data;
        REG_KEY1:  key1_r  <= cfg_data;
        REG_KEY2:  key2_r  <= cfg_data;
        REG_KEY3:  key3_r  <= cfg_data;
        REG_NONCE: nonce_r <= cfg_data;
        REG_KSIZE: ksize_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // word side
  assign need_new    = in_restart | (wp_r == 3'd0);
  assign avail       = ~need_new | (in_restart ? zero_vld_r : next_vld_r);
  assign in_stall    = ~(avail & (~out_vld_r | ~out_stall));
  assign acc         = in_valid & ~in_stall;
  assign consume_new = acc & need_new;
  assign new_blk     = in_restart ? zero_buf_r : next_buf_r;
  assign blk         = need_new ? new_blk : cur_r;
  assign p           = need_new ? 3'd0 : wp_r;
  assign ks          = {blk[{p, 1'b1}], blk[{p, 1'b0}]};
  assign cnt         = (in_byte_count > 4'd8) ? 4'd8 : in_byte_count;

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      mask[8*b +: 8] = (4'(b) < cnt) ? 8'hff : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      wp_r      <= 3'd0;
      ctr_r     <= '0;
    end else begin
      if (acc) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
      if (acc) begin
        wp_r <= p + 3'd1;
        if (in_restart) begin
          ctr_r <= 64'd1;
        end else if (need_new) begin
          ctr_r <= ctr_r + 64'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_data_r <= (in_data_in ^ ks) & mask;
      out_cnt_r  <= cnt;
      if (need_new) begin
        cur_r <= new_blk;
      end
    end
  end

  assign out_valid    = out_vld_r;
  assign out_data_out = out_data_r;
  assign out_count    = out_cnt_r;

  // block prefetch
  assign kill.all_k  = cfg_wr;
  assign kill.next_k = acc & in_restart;

  assign req_vld = ~cfg_wr & ~consume_new & (~zero_have_r | ~next_have_r);
  assign req_tag = zero_have_r ? TAG_NEXT : TAG_ZERO;
  assign req_ctr = zero_have_r ? ctr_r : 64'd0;

  always_comb begin
    logic [7:0][31:0] k;
    quad_t sig;
    k = {key3_r, key2_r, key1_r, key0_r};
    sig = SIGMA32;
    if (ksize_r == KEY_64) begin
      sig = SIGMA8;
      k[7:2] = {k[1:0], k[1:0], k[1:0]};
    end else if (ksize_r == KEY_128) begin
      sig = SIGMA16;
      k[7:4] = k[3:0];
    end
    req_state = {sig[3], k[7], k[6], k[5], k[4], sig[2], req_ctr, nonce_r,
                 sig[1], k[3], k[2], k[1], k[0], sig[0]};
  end

  salsa_core #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .kill      (kill),
    .req_vld   (req_vld),
    .req_tag   (req_tag),
    .req_state (req_state),
    .blk_vld   (blk_vld),
    .blk_tag   (blk_tag),
    .blk_data  (blk_data)
  );

  assign land_zero = blk_vld & ~kill.all_k & (blk_tag == TAG_ZERO);
  assign land_next = blk_vld & ~kill.all_k & ~kill.next_k & (blk_tag == TAG_NEXT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_vld_r  <= 1'b0;
      next_vld_r  <= 1'b0;
      zero_have_r <= 1'b0;
      next_have_r <= 1'b0;
    end else if (cfg_wr) begin
      zero_vld_r  <= 1'b0;
      next_vld_r  <= 1'b0;
      zero_have_r <= 1'b0;
      next_have_r <= 1'b0;
    end else begin
      if (req_vld && req_tag == TAG_ZERO) begin
        zero_have_r <= 1'b1;
      end
      if (land_zero) begin
        zero_vld_r <= 1'b1;
      end
      if (consume_new) begin
        next_vld_r  <= 1'b0;
        next_have_r <= 1'b0;
      end else begin
        if (req_vld && req_tag == TAG_NEXT) begin
          next_have_r <= 1'b1;
        end
        if (land_next) begin
          next_vld_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (land_zero) begin
      zero_buf_r <= blk_data;
    end
    if (land_next) begin
      next_buf_r <= blk_data;
    end
  end

`include "salsa_stream_cipher_assert.svh"

  `SALSA_ASSERT_NOW(a_restart_has_blk, acc && in_restart, zero_vld_r)
  `SALSA_ASSERT_NOW(a_next_has_blk, acc && need_new && !in_restart, next_vld_r)
  `SALSA_ASSERT_NOW(a_no_overwrite, land_next, !next_vld_r)
  `SALSA_ASSERT_NEXT(a_cfg_flush, cfg_wr, !zero_have_r && !next_have_r)

endmodule
`default_nettype wire
